[design/power_button_sequencer_top_defines.svh]
// ---------------------------------------------------------------------------
// Power button sequencer assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef POWER_BUTTON_SEQUENCER_TOP_DEFINES_SVH
`define POWER_BUTTON_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PBS_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("pbs check failed");

// Next-cycle implication, disabled while in reset.
`define PBS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("pbs check failed");

`endif

[design/pbs_pkg.sv]
// ---------------------------------------------------------------------------
// Power button sequencer package
// Widths, codes, reset values and shared structs for the sequencer.
// ---------------------------------------------------------------------------
package pbs_pkg;

    localparam int TIMER_BITS = 24;
    localparam int CFG_W      = 24;
    localparam int CLICK_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // Divide by ten via reciprocal: floor(x/10) == (x * 13421773) >> 27 for x < 2^26
    localparam int                 SLEEP_DIVISOR = 10;
    localparam logic [CFG_W-1:0]   SLEEP_RECIP   = 24'd13421773;
    localparam int                 SLEEP_SHIFT   = 27;
    localparam logic [3:0]         SLEEP_PERIODS = 4'd10;

    localparam logic [CFG_W-1:0]   SLEEP_TIMEOUT_RST = 24'd30000;
    localparam logic [CFG_W-1:0]   SLEEP_TARGET_RST  = CFG_W'(30000 / SLEEP_DIVISOR);
    localparam logic [CFG_W-1:0]   SHUTDOWN_RST      = 24'd10000;
    localparam logic [CLICK_W-1:0] CLICK_LIMIT_RST   = 16'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_LIMIT      = 2'd2;

    typedef enum logic [2:0] {
        FN_TICK       = 3'd0,
        FN_BTN_DOWN   = 3'd1,
        FN_BTN_UP     = 3'd2,
        FN_HOST_OFF   = 3'd3,
        FN_HOST_READY = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        MODE_STANDBY      = 3'd0,
        MODE_BOOT_RELEASE = 3'd1,
        MODE_BOOT_WAIT    = 3'd2,
        MODE_ON           = 3'd3,
        MODE_SHUTDOWN     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        PAT_OFF     = 3'd0,
        PAT_SOLID   = 3'd1,
        PAT_BREATHE = 3'd2,
        PAT_WAITON  = 3'd3,
        PAT_WAITOFF = 3'd4
    } pattern_t;

    typedef struct packed {
        logic [CFG_W-1:0]   sleep_target;
        logic [CFG_W-1:0]   shutdown_target;
        logic [CLICK_W-1:0] click_limit;
    } cfg_t;

    typedef struct packed {
        mode_t    power_state;
        pattern_t led_pattern;
        logic     button_held;
        logic     power_on_pulse;
        logic     shutdown_pulse;
        logic     force_off_pulse;
        logic     sleep_pulse;
    } result_t;

endpackage

[design/pbs_cfg.sv]
// ---------------------------------------------------------------------------
// Power button sequencer configuration registers
// Holds the timer targets in compare-ready form and the click limit.
// ---------------------------------------------------------------------------
module pbs_cfg
    import pbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    logic [2*CFG_W-1:0] recip_prod;
    logic [CFG_W-1:0]   sleep_div;
    logic [CFG_W-1:0]   sleep_target_next;
    logic [CFG_W-1:0]   shutdown_target_next;

    logic [CFG_W-1:0]   sleep_target_reg;
    logic [CFG_W-1:0]   shutdown_target_reg;
    logic [CLICK_W-1:0] click_limit_reg;

    // One sleep period is a tenth of the timeout, never less than one tick
    assign recip_prod = {{CFG_W{1'b0}}, cfg_wdata} * {{CFG_W{1'b0}}, SLEEP_RECIP};
    assign sleep_div  = CFG_W'(recip_prod >> SLEEP_SHIFT);
    assign sleep_target_next = (sleep_div == '0) ? CFG_W'(1) : sleep_div;
    assign shutdown_target_next = (cfg_wdata == '0) ? CFG_W'(1) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_target_reg    <= SLEEP_TARGET_RST;
            shutdown_target_reg <= SHUTDOWN_RST;
            click_limit_reg     <= CLICK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLEEP_TIMEOUT:    sleep_target_reg    <= sleep_target_next;
                CFG_SHUTDOWN_TIMEOUT: shutdown_target_reg <= shutdown_target_next;
                CFG_CLICK_LIMIT:      click_limit_reg     <= cfg_wdata[CLICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.sleep_target    = sleep_target_reg;
    assign cfg.shutdown_target = shutdown_target_reg;
    assign cfg.click_limit     = click_limit_reg;

endmodule

[design/pbs_core.sv]
// ---------------------------------------------------------------------------
// Power button sequencer core
// Sequencer state and the one-word step update with its result.
// ---------------------------------------------------------------------------
module pbs_core
    import pbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [2:0]         func,
    input  logic [CLICK_W-1:0] hold_time,
    input  cfg_t               cfg,
    output result_t            result
);

    typedef enum logic [1:0] {
        TK_IDLE     = 2'd0,
        TK_SLEEP    = 2'd1,
        TK_SHUTDOWN = 2'd2
    } timer_kind_t;

    localparam logic [TIMER_BITS-1:0] COUNT_MAX = {TIMER_BITS{1'b1}};

    mode_t                 mode_reg,    mode_next;
    logic [TIMER_BITS-1:0] count_reg,   count_next;
    timer_kind_t           kind_reg,    kind_next;
    logic [3:0]            periods_reg, periods_next;
    pattern_t              pattern_reg, pattern_next;
    logic                  held_reg,    held_next;

    logic [TIMER_BITS-1:0] count_inc;
    logic                  sleep_hit;
    logic                  shut_hit;
    logic                  is_click;
    logic                  to_standby;
    logic                  p_on, p_shut, p_force, p_sleep;

    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign sleep_hit = CMP_W'(count_inc) >= CMP_W'(cfg.sleep_target);
    assign shut_hit  = CMP_W'(count_inc) >= CMP_W'(cfg.shutdown_target);
    assign is_click  = hold_time < cfg.click_limit;

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        periods_next  = periods_reg;
        pattern_next  = pattern_reg;
        held_next     = held_reg;
        to_standby    = 1'b0;
        p_on          = 1'b0;
        p_shut        = 1'b0;
        p_force       = 1'b0;
        p_sleep       = 1'b0;

        if (mode_reg > MODE_SHUTDOWN)
        begin
            to_standby = 1'b1;
        end
        else
        begin
            case (func_t'(func))
                FN_TICK:
                begin
                    if (kind_reg != TK_IDLE)
                    begin
                        count_next = count_inc;
                        if (kind_reg == TK_SLEEP)
                        begin
                            if (sleep_hit)
                            begin
                                count_next   = '0;
                                periods_next = periods_reg + 1'b1;
                                if (periods_next == 4'd1)
                                    pattern_next = PAT_OFF;
                                if (periods_next >= SLEEP_PERIODS)
                                begin
                                    p_sleep   = 1'b1;
                                    kind_next = TK_IDLE;
                                end
                            end
                        end
                        else if (shut_hit)
                        begin
                            kind_next  = TK_IDLE;
                            count_next = '0;
                            if (mode_reg == MODE_SHUTDOWN)
                            begin
                                p_force    = 1'b1;
                                to_standby = 1'b1;
                            end
                        end
                    end
                end
                FN_BTN_DOWN:
                begin
                    held_next = 1'b1;
                    if (mode_reg == MODE_STANDBY)
                    begin
                        kind_next    = TK_IDLE;
                        p_on         = 1'b1;
                        pattern_next = PAT_WAITON;
                        mode_next    = MODE_BOOT_RELEASE;
                    end
                end
                FN_BTN_UP:
                begin
                    held_next = 1'b0;
                    case (mode_reg)
                        MODE_BOOT_RELEASE: mode_next = MODE_BOOT_WAIT;
                        MODE_BOOT_WAIT:
                        begin
                            if (!is_click)
                            begin
                                p_force    = 1'b1;
                                to_standby = 1'b1;
                            end
                        end
                        MODE_ON:
                        begin
                            if (is_click)
                            begin
                                p_shut       = 1'b1;
                                kind_next    = TK_SHUTDOWN;
                                count_next   = '0;
                                pattern_next = PAT_WAITOFF;
                                mode_next    = MODE_SHUTDOWN;
                            end
                            else
                            begin
                                p_force    = 1'b1;
                                to_standby = 1'b1;
                            end
                        end
                        MODE_SHUTDOWN:
                        begin
                            if (!is_click)
                            begin
                                p_force    = 1'b1;
                                to_standby = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                FN_HOST_OFF:
                begin
                    // Off in standby or before the button is released just restarts standby; later it is forced
                    if (mode_reg != MODE_STANDBY && mode_reg != MODE_BOOT_RELEASE)
                        p_force = 1'b1;
                    to_standby = 1'b1;
                end
                FN_HOST_READY:
                begin
                    if (mode_reg == MODE_STANDBY)
                    begin
                        kind_next    = TK_IDLE;
                        p_on         = 1'b1;
                        pattern_next = PAT_SOLID;
                        mode_next    = MODE_ON;
                    end
                    else if (mode_reg != MODE_SHUTDOWN)
                    begin
                        pattern_next = PAT_SOLID;
                        mode_next    = MODE_ON;
                    end
                end
                default: ;
            endcase
        end

        // Standby entry restarts the sleep timer from the first period
        if (to_standby)
        begin
            mode_next    = MODE_STANDBY;
            pattern_next = PAT_BREATHE;
            kind_next    = TK_SLEEP;
            count_next   = '0;
            periods_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_STANDBY;
            count_reg   <= '0;
            kind_reg    <= TK_SLEEP;
            periods_reg <= '0;
            pattern_reg <= PAT_BREATHE;
            held_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            kind_reg    <= kind_next;
            periods_reg <= periods_next;
            pattern_reg <= pattern_next;
            held_reg    <= held_next;
        end
    end

    assign result.power_state     = mode_next;
    assign result.led_pattern     = pattern_next;
    assign result.button_held     = held_next;
    assign result.power_on_pulse  = p_on;
    assign result.shutdown_pulse  = p_shut;
    assign result.force_off_pulse = p_force;
    assign result.sleep_pulse     = p_sleep;

endmodule

[design/power_button_sequencer_top.sv]
// ---------------------------------------------------------------------------
// Power button sequencer top level
// Button, host and tick events in; power state, LED code and pulses out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event word: func plus
//   hold_time, the latter only looked at with a button release. Every
//   accepted word yields exactly one result word on the output channel
//   (out_valid / out_stall) with the new power state, LED pattern code,
//   held flag and the four one-word pulses.
//   Path: an accepted word waits in the input register, then moves into the
//   result register, where out_valid rises, once the result slot is free.
//   Throughput: one word per cycle while out_stall is low; the step update
//   is a single pass from the input register through the state logic.
//   Stall: while out_stall holds a waiting result, the input register can
//   still take one more word; after that in_stall rises until the result
//   is taken. State only advances when a word moves into the result slot.
//   Reset: standby, breathe pattern, sleep timer running from zero, default
//   timeouts (30000 / 10000 ticks) and click limit 30. Configuration writes
//   take effect at the next edge and are meant for idle periods only.
// ---------------------------------------------------------------------------
`include "power_button_sequencer_top_defines.svh"

module power_button_sequencer_top
    import pbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // event input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           func,
    input  logic [CLICK_W-1:0]   hold_time,
    // result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           power_state,
    output logic [2:0]           led_pattern,
    output logic                 button_held,
    output logic                 power_on_pulse,
    output logic                 shutdown_pulse,
    output logic                 force_off_pulse,
    output logic                 sleep_pulse
);

    cfg_t    cfg;
    result_t step_result;

    logic               in_valid_reg;
    logic [2:0]         func_reg;
    logic [CLICK_W-1:0] hold_reg;
    logic               out_valid_reg;
    result_t            result_reg;

    logic out_free;
    logic step_en;
    logic in_take;

    pbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The result slot frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // Advance the state exactly when an event word moves into the result slot
    assign step_en  = in_valid_reg && out_free;
    // Hold the input word while it cannot move on
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    pbs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .func      (func_reg),
        .hold_time (hold_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step_en)
                in_valid_reg <= 1'b0;

            if (step_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            hold_reg <= hold_time;
        end
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid       = out_valid_reg;
    assign power_state     = result_reg.power_state;
    assign led_pattern     = result_reg.led_pattern;
    assign button_held     = result_reg.button_held;
    assign power_on_pulse  = result_reg.power_on_pulse;
    assign shutdown_pulse  = result_reg.shutdown_pulse;
    assign force_off_pulse = result_reg.force_off_pulse;
    assign sleep_pulse     = result_reg.sleep_pulse;

    // At most one pulse per result word
    `PBS_ASSERT_IMPL(a_one_pulse, clk, rst_n, out_valid,
        $countones({power_on_pulse, shutdown_pulse, force_off_pulse, sleep_pulse}) <= 1)
    // A forced off always lands in standby with the breathe pattern
    `PBS_ASSERT_IMPL(a_force_standby, clk, rst_n, out_valid && force_off_pulse,
        power_state == MODE_STANDBY && led_pattern == PAT_BREATHE)
    // The sleep timeout only fires in standby after the LED went dark
    `PBS_ASSERT_IMPL(a_sleep_dark, clk, rst_n, out_valid && sleep_pulse,
        power_state == MODE_STANDBY && led_pattern == PAT_OFF)
    // A stepped word always shows up as a result in the next cycle
    `PBS_ASSERT_NEXT(a_step_out, clk, rst_n, step_en, out_valid)

endmodule
